FILE: hdl/psot_pkg.sv
// Shared types and constants for the point-on-segment test pipeline.
`default_nettype none
package psot_pkg;
	localparam int TOL_W = 48;
	localparam int VERDICT_W = 3;

	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_OUTSIDE    = 3'd0,
		VERDICT_INTERIOR   = 3'd1,
		VERDICT_HIT_A      = 3'd2,
		VERDICT_HIT_B      = 3'd3,
		VERDICT_DEGENERATE = 3'd4
	} verdict_t;

	// Per-item control that travels alongside the divider lanes.
	typedef struct packed {
		verdict_t   pre;
		logic       decided;
		logic [2:0] use_plane;
		logic       inside_len;
	} side_t;
endpackage
`default_nettype wire

FILE: hdl/psot_front.sv
// Front end: differences, products, squared lengths, classification and numerators.
`default_nettype none
module psot_front #(
	parameter int CW = 24,
	parameter int FW = 16,
	parameter int IW = 20
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          adv,
	input  wire logic                          in_valid,
	input  wire logic [2:0][CW-1:0]            a,
	input  wire logic [2:0][CW-1:0]            b,
	input  wire logic [2:0][CW-1:0]            p,
	input  wire logic [IW-1:0]                 id_a,
	input  wire logic [IW-1:0]                 id_b,
	input  wire logic [psot_pkg::TOL_W-1:0]    tolerance,
	output logic                               out_valid,
	output logic [2:0][2*(CW+1):0]             out_rem,
	output logic [2:0][2*(CW+1)+FW-1:0]        out_nq,
	output logic [2:0][2*(CW+1):0]             out_den,
	output psot_pkg::side_t                    out_side,
	output logic [IW-1:0]                      out_hit
);
	localparam int MW   = CW + 1;
	localparam int SQW  = 2 * MW;
	localparam int DSW  = SQW + 2;
	localparam int LPW  = SQW + 1;
	localparam int OW   = SQW + 1;
	localparam int QW   = SQW + FW;
	localparam int NW   = 2 * OW + FW;
	localparam int SQ2W = 2 * OW;
	localparam int HW   = (OW + 1) / 2;
	localparam int HIW  = OW - HW;
	localparam int XW   = (DSW > psot_pkg::TOL_W) ? DSW : psot_pkg::TOL_W;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [MW-1:0]  e_s1 [3];
	logic signed [MW-1:0]  f_s1 [3];
	logic signed [MW-1:0]  g_s1 [3];
	logic [IW-1:0]         ida_s1, idb_s1, ida_s2, idb_s2, ida_s3, idb_s3;

	logic signed [SQW-1:0] ee_s2 [3];
	logic signed [SQW-1:0] ff_s2 [3];
	logic signed [SQW-1:0] gg_s2 [3];
	logic signed [SQW-1:0] pr1_s2 [3];
	logic signed [SQW-1:0] pr2_s2 [3];

	logic [DSW-1:0]        len_s3, d0_s3, d1_s3;
	logic [LPW-1:0]        lp_s3 [3];
	logic signed [OW-1:0]  o_s3 [3];

	logic [OW-1:0]         mo_s4 [3];
	logic [LPW-1:0]        den_s4 [3];
	psot_pkg::side_t       side_s4;
	logic [IW-1:0]         hit_s4;

	logic [2*HW-1:0]       ll_s5 [3];
	logic [OW-1:0]         lh_s5 [3];
	logic [2*HIW-1:0]      hh_s5 [3];
	logic [LPW-1:0]        den_s5 [3];
	psot_pkg::side_t       side_s5;
	logic [IW-1:0]         hit_s5;

	logic [LPW-1:0]        rem_s6 [3];
	logic [QW-1:0]         nq_s6 [3];
	logic [LPW-1:0]        den_s6 [3];
	psot_pkg::side_t       side_s6;
	logic [IW-1:0]         hit_s6;

	logic                  deg, hit_a, hit_b;
	logic [SQ2W-1:0]       sq [3];
	logic [NW-1:0]         num [3];
	psot_pkg::side_t       side_next;
	logic [IW-1:0]         hit_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_comb begin
		deg   = XW'(len_s3) < XW'(tolerance);
		hit_a = XW'(d0_s3) < XW'(tolerance);
		hit_b = XW'(d1_s3) < XW'(tolerance);
		side_next.decided    = deg || hit_a || hit_b;
		side_next.inside_len = (d1_s3 < len_s3) && (d0_s3 < len_s3);
		for (int k = 0; k < 3; k++) begin
			side_next.use_plane[k] = XW'(lp_s3[k]) > XW'(tolerance);
		end
		hit_next = '0;
		if (deg) begin
			side_next.pre = psot_pkg::VERDICT_DEGENERATE;
		end else if (hit_a) begin
			side_next.pre = psot_pkg::VERDICT_HIT_A;
			hit_next = ida_s3;
		end else if (hit_b) begin
			side_next.pre = psot_pkg::VERDICT_HIT_B;
			hit_next = idb_s3;
		end else begin
			side_next.pre = psot_pkg::VERDICT_OUTSIDE;
		end
	end

	// The square of the cross product is rebuilt from its three partial products.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sq[k] = (SQ2W'(hh_s5[k]) << (2 * HW)) + (SQ2W'(lh_s5[k]) << (HW + 1))
				+ SQ2W'(ll_s5[k]);
			num[k] = NW'(sq[k]) << FW;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				e_s1[k] <= $signed({b[k][CW-1], b[k]}) - $signed({a[k][CW-1], a[k]});
				f_s1[k] <= $signed({p[k][CW-1], p[k]}) - $signed({a[k][CW-1], a[k]});
				g_s1[k] <= $signed({p[k][CW-1], p[k]}) - $signed({b[k][CW-1], b[k]});
			end
			ida_s1 <= id_a;
			idb_s1 <= id_b;

			for (int k = 0; k < 3; k++) begin
				ee_s2[k] <= e_s1[k] * e_s1[k];
				ff_s2[k] <= f_s1[k] * f_s1[k];
				gg_s2[k] <= g_s1[k] * g_s1[k];
			end
			pr1_s2[0] <= e_s1[0] * f_s1[1];
			pr2_s2[0] <= e_s1[1] * f_s1[0];
			pr1_s2[1] <= e_s1[1] * f_s1[2];
			pr2_s2[1] <= e_s1[2] * f_s1[1];
			pr1_s2[2] <= e_s1[2] * f_s1[0];
			pr2_s2[2] <= e_s1[0] * f_s1[2];
			ida_s2 <= ida_s1;
			idb_s2 <= idb_s1;

			len_s3 <= DSW'($unsigned(ee_s2[0])) + DSW'($unsigned(ee_s2[1]))
				+ DSW'($unsigned(ee_s2[2]));
			d0_s3 <= DSW'($unsigned(ff_s2[0])) + DSW'($unsigned(ff_s2[1]))
				+ DSW'($unsigned(ff_s2[2]));
			d1_s3 <= DSW'($unsigned(gg_s2[0])) + DSW'($unsigned(gg_s2[1]))
				+ DSW'($unsigned(gg_s2[2]));
			lp_s3[0] <= LPW'($unsigned(ee_s2[0])) + LPW'($unsigned(ee_s2[1]));
			lp_s3[1] <= LPW'($unsigned(ee_s2[1])) + LPW'($unsigned(ee_s2[2]));
			lp_s3[2] <= LPW'($unsigned(ee_s2[2])) + LPW'($unsigned(ee_s2[0]));
			for (int k = 0; k < 3; k++) begin
				o_s3[k] <= OW'(pr1_s2[k]) - OW'(pr2_s2[k]);
			end
			ida_s3 <= ida_s2;
			idb_s3 <= idb_s2;

			for (int k = 0; k < 3; k++) begin
				mo_s4[k]  <= o_s3[k][OW-1] ? $unsigned(-o_s3[k]) : $unsigned(o_s3[k]);
				den_s4[k] <= lp_s3[k];
			end
			side_s4 <= side_next;
			hit_s4  <= hit_next;

			for (int k = 0; k < 3; k++) begin
				ll_s5[k]  <= mo_s4[k][HW-1:0] * mo_s4[k][HW-1:0];
				lh_s5[k]  <= mo_s4[k][HW-1:0] * mo_s4[k][OW-1:HW];
				hh_s5[k]  <= mo_s4[k][OW-1:HW] * mo_s4[k][OW-1:HW];
				den_s5[k] <= den_s4[k];
			end
			side_s5 <= side_s4;
			hit_s5  <= hit_s4;

			// The quotient fits in QW bits, so the bits above start as the remainder.
			for (int k = 0; k < 3; k++) begin
				rem_s6[k] <= num[k][QW +: LPW];
				nq_s6[k]  <= num[k][QW-1:0];
				den_s6[k] <= den_s5[k];
			end
			side_s6 <= side_s5;
			hit_s6  <= hit_s5;
		end
	end

	always_comb begin
		out_valid = v_s6;
		for (int k = 0; k < 3; k++) begin
			out_rem[k] = rem_s6[k];
			out_nq[k]  = nq_s6[k];
			out_den[k] = den_s6[k];
		end
		out_side = side_s6;
		out_hit  = hit_s6;
	end
endmodule
`default_nettype wire

FILE: hdl/psot_divider.sv
// Three-lane restoring divider, one quotient bit per pipeline stage.
`default_nettype none
module psot_divider #(
	parameter int LPW = 51,
	parameter int QW  = 66,
	parameter int IW  = 20
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  adv,
	input  wire logic                  in_valid,
	input  wire logic [2:0][LPW-1:0]   in_rem,
	input  wire logic [2:0][QW-1:0]    in_nq,
	input  wire logic [2:0][LPW-1:0]   in_den,
	input  wire psot_pkg::side_t       in_side,
	input  wire logic [IW-1:0]         in_hit,
	output logic                       out_valid,
	output logic [2:0][QW-1:0]         out_quot,
	output psot_pkg::side_t            out_side,
	output logic [IW-1:0]              out_hit
);
	logic                  vld_s  [QW];
	logic [2:0][LPW-1:0]   rem_s  [QW];
	logic [2:0][QW-1:0]    nq_s   [QW];
	logic [2:0][LPW-1:0]   den_s  [QW];
	psot_pkg::side_t       side_s [QW];
	logic [IW-1:0]         hit_s  [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic                src_vld;
		logic [2:0][LPW-1:0] src_rem;
		logic [2:0][QW-1:0]  src_nq;
		logic [2:0][LPW-1:0] src_den;
		psot_pkg::side_t     src_side;
		logic [IW-1:0]       src_hit;
		logic [2:0][LPW:0]   trial;
		logic [2:0]          ge;
		logic [2:0][LPW-1:0] rem_next;
		logic [2:0][QW-1:0]  nq_next;

		if (k == 0) begin : g_first
			assign src_vld  = in_valid;
			assign src_rem  = in_rem;
			assign src_nq   = in_nq;
			assign src_den  = in_den;
			assign src_side = in_side;
			assign src_hit  = in_hit;
		end else begin : g_next
			assign src_vld  = vld_s[k-1];
			assign src_rem  = rem_s[k-1];
			assign src_nq   = nq_s[k-1];
			assign src_den  = den_s[k-1];
			assign src_side = side_s[k-1];
			assign src_hit  = hit_s[k-1];
		end

		// The numerator bit shifts out of the top while the quotient bit enters at the bottom.
		always_comb begin
			for (int l = 0; l < 3; l++) begin
				trial[l]    = {src_rem[l], src_nq[l][QW-1]};
				ge[l]       = trial[l] >= {1'b0, src_den[l]};
				rem_next[l] = ge[l] ? LPW'(trial[l] - {1'b0, src_den[l]})
					: trial[l][LPW-1:0];
				nq_next[l]  = {src_nq[l][QW-2:0], ge[l]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k]  <= rem_next;
				nq_s[k]   <= nq_next;
				den_s[k]  <= src_den;
				side_s[k] <= src_side;
				hit_s[k]  <= src_hit;
			end
		end
	end

	assign out_valid = vld_s[QW-1];
	assign out_quot  = nq_s[QW-1];
	assign out_side  = side_s[QW-1];
	assign out_hit   = hit_s[QW-1];
endmodule
`default_nettype wire

FILE: hdl/psot_select.sv
// Back end: merge equal distances, sum the two largest and decide the verdict.
`default_nettype none
module psot_select #(
	parameter int QW = 66,
	parameter int FW = 16,
	parameter int IW = 20
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          adv,
	input  wire logic                          in_valid,
	input  wire logic [2:0][QW-1:0]            in_quot,
	input  wire psot_pkg::side_t               in_side,
	input  wire logic [IW-1:0]                 in_hit,
	input  wire logic [psot_pkg::TOL_W-1:0]    tolerance,
	output logic                               out_valid,
	output psot_pkg::verdict_t                 out_verdict,
	output logic [IW-1:0]                      out_hit
);
	localparam int SW  = QW + 1;
	localparam int TW  = psot_pkg::TOL_W + FW;
	localparam int CMW = (SW > TW) ? SW : TW;

	logic                v_s1, v_s2, v_s3;
	logic [2:0][QW-1:0]  z_s1;
	psot_pkg::side_t     side_s1, side_s2;
	logic [IW-1:0]       hit_s1, hit_s2;
	logic                le01_s2, le02_s2, le12_s2;
	logic [SW-1:0]       s01_s2, s02_s2, s12_s2;
	psot_pkg::verdict_t  verdict_s3;
	logic [IW-1:0]       hit_s3;

	logic [2:0]          keep;
	logic [SW-1:0]       top2;
	logic [TW-1:0]       thr;
	psot_pkg::verdict_t  verdict_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// A plane whose value repeats an earlier plane's value is dropped; unused values read zero,
	// so the sum of the two largest also covers one or two remaining values.
	always_comb begin
		keep[0] = in_side.use_plane[0];
		keep[1] = in_side.use_plane[1]
			&& !(in_side.use_plane[0] && in_quot[1] == in_quot[0]);
		keep[2] = in_side.use_plane[2]
			&& !(in_side.use_plane[0] && in_quot[2] == in_quot[0])
			&& !(in_side.use_plane[1] && in_quot[2] == in_quot[1]);
	end

	always_comb begin
		if (le01_s2 && le02_s2) begin
			top2 = s12_s2;
		end else if (le12_s2) begin
			top2 = s02_s2;
		end else begin
			top2 = s01_s2;
		end
		thr = TW'(tolerance) << FW;
		if (side_s2.decided) begin
			verdict_next = side_s2.pre;
		end else if (side_s2.use_plane == 3'b000) begin
			verdict_next = psot_pkg::VERDICT_OUTSIDE;
		end else if (CMW'(top2) > CMW'(thr)) begin
			verdict_next = psot_pkg::VERDICT_OUTSIDE;
		end else if (side_s2.inside_len) begin
			verdict_next = psot_pkg::VERDICT_INTERIOR;
		end else begin
			verdict_next = psot_pkg::VERDICT_OUTSIDE;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				z_s1[k] <= keep[k] ? in_quot[k] : '0;
			end
			side_s1 <= in_side;
			hit_s1  <= in_hit;

			le01_s2 <= z_s1[0] <= z_s1[1];
			le02_s2 <= z_s1[0] <= z_s1[2];
			le12_s2 <= z_s1[1] <= z_s1[2];
			s01_s2  <= SW'(z_s1[0]) + SW'(z_s1[1]);
			s02_s2  <= SW'(z_s1[0]) + SW'(z_s1[2]);
			s12_s2  <= SW'(z_s1[1]) + SW'(z_s1[2]);
			side_s2 <= side_s1;
			hit_s2  <= hit_s1;

			verdict_s3 <= verdict_next;
			hit_s3     <= hit_s2;
		end
	end

	assign out_valid   = v_s3;
	assign out_verdict = verdict_s3;
	assign out_hit     = hit_s3;
endmodule
`default_nettype wire

FILE: hdl/point_on_segment_test_core.sv
// Top level of the 3D point-on-segment tolerance test.
// Data passes through the front end, the divider and the back end in turn;
// the divider spends one stage per quotient bit, 2*COORD_BITS + FRAC_BITS + 2 stages.
// Throughput: one item per cycle; the whole pipeline holds while the output item waits.
// Reset: arst_n clears all valid bits and sets tolerance_q to zero; no clearing pass.
`default_nettype none
module point_on_segment_test_core #(
	parameter int COORD_BITS = 24,
	parameter int FRAC_BITS  = 16,
	parameter int ID_BITS    = 20
) (
	input  wire logic                                           clk,
	input  wire logic                                           arst_n,
	input  wire logic                                           cfg_we,
	input  wire logic [psot_pkg::TOL_W-1:0]                     cfg_wdata,
	input  wire logic                                           s_axis_tvalid,
	output logic                                                s_axis_tready,
	// first_x, first_y, first_z, first_id, second_x, second_y, second_z, second_id,
	// query_x, query_y, query_z, then zero fill
	input  wire logic [((9*COORD_BITS+2*ID_BITS+7)/8)*8-1:0]    s_axis_tdata,
	output logic                                                m_axis_tvalid,
	input  wire logic                                           m_axis_tready,
	// verdict, hit_id, then zero fill
	output logic [((psot_pkg::VERDICT_W+ID_BITS+7)/8)*8-1:0]    m_axis_tdata
);
	localparam int CW   = COORD_BITS;
	localparam int IW   = ID_BITS;
	localparam int LPW  = 2 * (CW + 1) + 1;
	localparam int QW   = 2 * (CW + 1) + FRAC_BITS;
	localparam int OUTW = ((psot_pkg::VERDICT_W + IW + 7) / 8) * 8;

	logic [psot_pkg::TOL_W-1:0] tolerance_q;
	logic                       adv;
	logic [2:0][CW-1:0]         a, b, p;
	logic [IW-1:0]              id_a, id_b;

	logic                       fr_valid;
	logic [2:0][LPW-1:0]        fr_rem;
	logic [2:0][QW-1:0]         fr_nq;
	logic [2:0][LPW-1:0]        fr_den;
	psot_pkg::side_t            fr_side;
	logic [IW-1:0]              fr_hit;

	logic                       dv_valid;
	logic [2:0][QW-1:0]         dv_quot;
	psot_pkg::side_t            dv_side;
	logic [IW-1:0]              dv_hit;

	psot_pkg::verdict_t         res_verdict;
	logic [IW-1:0]              res_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= '0;
		end else if (cfg_we) begin
			tolerance_q <= cfg_wdata;
		end
	end

	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	always_comb begin
		a[0] = s_axis_tdata[0*CW +: CW];
		a[1] = s_axis_tdata[1*CW +: CW];
		a[2] = s_axis_tdata[2*CW +: CW];
		id_a = s_axis_tdata[3*CW +: IW];
		b[0] = s_axis_tdata[3*CW+IW +: CW];
		b[1] = s_axis_tdata[4*CW+IW +: CW];
		b[2] = s_axis_tdata[5*CW+IW +: CW];
		id_b = s_axis_tdata[6*CW+IW +: IW];
		p[0] = s_axis_tdata[6*CW+2*IW +: CW];
		p[1] = s_axis_tdata[7*CW+2*IW +: CW];
		p[2] = s_axis_tdata[8*CW+2*IW +: CW];
	end

	psot_front #(
		.CW(CW),
		.FW(FRAC_BITS),
		.IW(IW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_valid(s_axis_tvalid),
		.a(a),
		.b(b),
		.p(p),
		.id_a(id_a),
		.id_b(id_b),
		.tolerance(tolerance_q),
		.out_valid(fr_valid),
		.out_rem(fr_rem),
		.out_nq(fr_nq),
		.out_den(fr_den),
		.out_side(fr_side),
		.out_hit(fr_hit)
	);

	psot_divider #(
		.LPW(LPW),
		.QW(QW),
		.IW(IW)
	) u_divider (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_valid(fr_valid),
		.in_rem(fr_rem),
		.in_nq(fr_nq),
		.in_den(fr_den),
		.in_side(fr_side),
		.in_hit(fr_hit),
		.out_valid(dv_valid),
		.out_quot(dv_quot),
		.out_side(dv_side),
		.out_hit(dv_hit)
	);

	psot_select #(
		.QW(QW),
		.FW(FRAC_BITS),
		.IW(IW)
	) u_select (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_valid(dv_valid),
		.in_quot(dv_quot),
		.in_side(dv_side),
		.in_hit(dv_hit),
		.tolerance(tolerance_q),
		.out_valid(m_axis_tvalid),
		.out_verdict(res_verdict),
		.out_hit(res_hit)
	);

	assign m_axis_tdata = OUTW'({res_hit, res_verdict});
endmodule
`default_nettype wire

FILE: tb/sv/point_on_segment_test_core_tb.sv
// Self-checking testbench for the point-on-segment tolerance test core.
`default_nettype none
module point_on_segment_test_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;

	typedef struct {
		logic signed [23:0] first_x, first_y, first_z;
		logic [19:0]        first_id;
		logic signed [23:0] second_x, second_y, second_z;
		logic [19:0]        second_id;
		logic signed [23:0] query_x, query_y, query_z;
	} segment_query_t;

	typedef struct {
		psot_pkg::verdict_t verdict;
		logic [19:0]        hit_id;
	} placement_t;

	function automatic logic [191:0] square_of(longint d);
		logic [191:0] m;
		m = (d < 0) ? -d : d;
		return m * m;
	endfunction

	function automatic logic [191:0] dist_sq3(longint u[3], longint v[3]);
		return square_of(u[0] - v[0]) + square_of(u[1] - v[1]) + square_of(u[2] - v[2]);
	endfunction

	// Exact placement of the query point relative to the segment.
	function automatic placement_t classify(segment_query_t s, logic [47:0] tol_sq);
		longint a[3], b[3], p[3];
		longint ex, ey, fx, fy, o;
		logic [191:0] len, d0, d1, lp, q, tol, sum, t;
		logic [191:0] vals[3];
		int n, u, v;
		bit dup;
		placement_t r;
		a = '{s.first_x, s.first_y, s.first_z};
		b = '{s.second_x, s.second_y, s.second_z};
		p = '{s.query_x, s.query_y, s.query_z};
		tol = {144'b0, tol_sq};
		len = dist_sq3(a, b);
		d0 = dist_sq3(a, p);
		d1 = dist_sq3(b, p);
		r.hit_id = '0;
		n = 0;
		if (len < tol) begin
			r.verdict = psot_pkg::VERDICT_DEGENERATE;
		end else if (d0 < tol) begin
			r.verdict = psot_pkg::VERDICT_HIT_A;
			r.hit_id = s.first_id;
		end else if (d1 < tol) begin
			r.verdict = psot_pkg::VERDICT_HIT_B;
			r.hit_id = s.second_id;
		end else begin
			for (int k = 0; k < 3; k++) begin
				u = k;
				v = (k + 1) % 3;
				ex = b[u] - a[u];
				ey = b[v] - a[v];
				fx = p[u] - a[u];
				fy = p[v] - a[v];
				lp = square_of(ex) + square_of(ey);
				if (lp <= tol) continue;
				o = ex * fy - ey * fx;
				q = (square_of(o) << FRAC) / lp;
				dup = 0;
				for (int j = 0; j < n; j++) if (vals[j] == q) dup = 1;
				if (!dup) begin
					vals[n] = q;
					n++;
				end
			end
			for (int i = 0; i < n; i++)
				for (int j = i + 1; j < n; j++)
					if (vals[j] < vals[i]) begin
						t = vals[i];
						vals[i] = vals[j];
						vals[j] = t;
					end
			if (n == 0) r.verdict = psot_pkg::VERDICT_OUTSIDE;
			else begin
				// Only the two largest distinct plane distances count.
				sum = (n == 1) ? vals[0] : (n == 2) ? vals[0] + vals[1] : vals[1] + vals[2];
				if (sum > (tol << FRAC)) r.verdict = psot_pkg::VERDICT_OUTSIDE;
				else if (d1 < len && d0 < len) r.verdict = psot_pkg::VERDICT_INTERIOR;
				else r.verdict = psot_pkg::VERDICT_OUTSIDE;
			end
		end
		return r;
	endfunction

	class placement_board;
		placement_t  pending_q[$];
		logic [47:0] tol_sq;
		int          errors;

		function void note(segment_query_t s);
			pending_q.insert(pending_q.size(), classify(s, tol_sq));
		endfunction

		function void check(logic [2:0] verdict, logic [19:0] hit_id);
			placement_t e;
			if (pending_q.size() == 0) begin
				$error("result with no item outstanding: verdict %0d hit_id %0d", verdict, hit_id);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			if (verdict !== e.verdict) begin
				$error("verdict: expected %0d, actual %0d", e.verdict, verdict);
				errors++;
			end
			if (hit_id !== e.hit_id) begin
				$error("hit_id: expected %0d, actual %0d", e.hit_id, hit_id);
				errors++;
			end
		endfunction
	endclass

	logic         clk = 0;
	logic         arst_n = 0;
	logic         cfg_we = 0;
	logic [47:0]  cfg_wdata = '0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [255:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [23:0]  m_axis_tdata;
	bit           idle_on = 1;
	placement_board board = new();

	point_on_segment_test_core i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end

	// Result side: random stalls, check on every accepted item.
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			g = idle_on ? $urandom_range(0, 10) : 0;
			repeat (g) begin
				m_axis_tready = 0;
				@(negedge clk);
			end
			m_axis_tready = 1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			board.check(m_axis_tdata[2:0], m_axis_tdata[22:3]);
		end
	end

	task automatic send(segment_query_t s);
		int g;
		@(negedge clk);
		g = idle_on ? $urandom_range(0, 10) : 0;
		repeat (g) begin
			s_axis_tvalid = 0;
			@(negedge clk);
		end
		s_axis_tvalid = 1;
		s_axis_tdata = {s.query_z, s.query_y, s.query_x, s.second_id, s.second_z,
			s.second_y, s.second_x, s.first_id, s.first_z, s.first_y, s.first_x};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		board.note(s);
	endtask

	task automatic set_tolerance(logic [47:0] value);
		@(negedge clk);
		s_axis_tvalid = 0;
		wait (board.pending_q.size() == 0);
		// Let the pipeline fully empty before touching the register.
		repeat (100) @(posedge clk);
		@(negedge clk);
		cfg_we = 1;
		cfg_wdata = value;
		board.tol_sq = value;
		@(negedge clk);
		cfg_we = 0;
	endtask

	function automatic logic signed [23:0] clip(longint v);
		if (v > 8388607) return 24'sd8388607;
		if (v < -8388608) return -24'sd8388608;
		return 24'(v);
	endfunction

	function automatic segment_query_t make_query(longint ax, longint ay, longint az,
			longint bx, longint by, longint bz, longint px, longint py, longint pz);
		segment_query_t s;
		s.first_x = clip(ax);  s.first_y = clip(ay);  s.first_z = clip(az);
		s.second_x = clip(bx); s.second_y = clip(by); s.second_z = clip(bz);
		s.query_x = clip(px);  s.query_y = clip(py);  s.query_z = clip(pz);
		s.first_id = 20'($urandom);
		s.second_id = 20'($urandom);
		return s;
	endfunction

	// Mostly points placed near the line through A and B, the rest raw noise.
	function automatic segment_query_t random_query();
		segment_query_t s;
		longint a[3], d[3], p[3];
		longint span, noise, t;
		if ($urandom_range(0, 9) < 3) begin
			s = make_query(0, 0, 0, 0, 0, 0, 0, 0, 0);
			{s.first_x, s.first_y, s.first_z, s.second_x, s.second_y} =
				{$urandom, $urandom, $urandom, 24'($urandom)};
			{s.second_z, s.query_x, s.query_y, s.query_z} = {$urandom, $urandom, $urandom};
			return s;
		end
		span = longint'(1) << $urandom_range(1, 23);
		case ($urandom_range(0, 5))
			0: noise = 0;
			1: noise = 1;
			2: noise = 5;
			3: noise = 60;
			4: noise = 700;
			default: noise = 5000;
		endcase
		t = $urandom_range(0, 9) == 0 ? longint'($urandom_range(0, 400)) - 72
			: longint'($urandom_range(0, 256));
		for (int k = 0; k < 3; k++) begin
			a[k] = longint'($urandom_range(0, 16777215)) - 8388608;
			d[k] = $urandom_range(0, 3) == 0 ? 0
				: longint'($urandom_range(0, 32'(2 * span))) - span;
			p[k] = a[k] + d[k] * t / 256 + longint'($urandom_range(0, 32'(2 * noise))) - noise;
		end
		return make_query(a[0], a[1], a[2], a[0] + d[0], a[1] + d[1], a[2] + d[2],
			p[0], p[1], p[2]);
	endfunction

	task automatic directed_queries();
		segment_query_t s;
		send(make_query(5, 5, 5, 5, 5, 5, 1000, 0, 0));             // degenerate segment
		send(make_query(0, 0, 0, 1000, 0, 0, 3, 0, 0));             // on A
		send(make_query(0, 0, 0, 1000, 0, 0, 998, 2, 0));           // on B
		send(make_query(0, 0, 0, 1000, 0, 0, 500, 3, 0));           // interior, axis aligned
		send(make_query(0, 0, 0, 1000, 0, 0, 1500, 0, 0));          // past B on the line
		send(make_query(0, 0, 0, 1000, 0, 0, 500, 400, 0));         // far off the line
		send(make_query(0, 0, 0, 600, 600, 600, 300, 300, 300));    // equal planes merge
		send(make_query(0, 0, 0, 7, 7, 7, 100, 100, 100));          // no usable plane
		send(make_query(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
			0, 0, 0));
		send(make_query(-8388608, 8388607, -8388608, 8388607, -8388608, 8388607,
			8388607, 8388607, 8388607));
		send(make_query(-8388608, 0, 0, 8388607, 0, 0, -8388608, -8388608, 8388607));
		s = make_query(0, 0, 0, 1000, 1000, 0, 1, 0, 0);
		s.first_id = 20'hFFFFF;
		send(s);
		s = make_query(0, 0, 0, 1000, 1000, 0, 1000, 999, 0);
		s.second_id = 20'hFFFFF;
		send(s);
		s = make_query(0, 0, 0, 1000, 1000, 0, 2, 0, 0);
		s.first_id = 0;
		send(s);
		send(make_query(100, -200, 300, -100, 200, -300, 1, -2, 3));
		send(make_query(0, 0, 0, 3000, 4000, 0, 1500, 2000, 9));
	endtask

	initial begin
		logic [47:0] tolerances[6];
		tolerances = '{48'd100, 48'd0, 48'd10000, 48'd2500000, 48'hFFFF_FFFF_FFFF, 48'd0};
		tolerances[5] = {16'($urandom_range(0, 65535)), $urandom};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		foreach (tolerances[i]) begin
			set_tolerance(tolerances[i]);
			if (i == 0) directed_queries();
			for (int n = 0; n < 340; n++) begin
				if (n % 100 == 0) idle_on = $urandom_range(0, 3) != 0;
				send(random_query());
			end
		end
		@(negedge clk);
		s_axis_tvalid = 0;
		idle_on = 1;
		wait (board.pending_q.size() == 0);
		repeat (100) @(posedge clk);
		if (board.errors == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire
